/* rtl/frve_pkg.sv */
// shared widths, constants, state encoding and status type for the frame rms envelope
package frve_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 16;
  localparam int SQ_W       = 2 * MAG_W - 1;
  localparam int HOP_W      = 13;
  localparam int MAX_HOP    = 4096;
  localparam int HOP_RESET  = 512;
  localparam int SUM_W      = 43;
  localparam int FRAC_SHIFT = 16;
  localparam int NUM_W      = SUM_W + FRAC_SHIFT;
  localparam int RAD_W      = NUM_W + (NUM_W % 2);
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int VOL_W      = 24;
  localparam int IDX_W      = 16;
  localparam int LEAD_SHIFT = 8;
  localparam int MUL_CNT_W  = $clog2(MAG_W);
  localparam int DIV_CNT_W  = $clog2(NUM_W);
  localparam int SQRT_CNT_W = $clog2(ROOT_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAD,
    S_MUL,
    S_CHECK,
    S_DIV,
    S_SQRT,
    S_EMIT,
    S_DONE
  } frve_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } frve_unit_stat_t;

endpackage

/* rtl/frve_div.sv */
// bit-serial restoring divider: scaled frame energy over the hop length, one quotient bit a cycle
module frve_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [frve_pkg::SUM_W-1:0]  dividend,
  input  logic [frve_pkg::HOP_W-1:0]  divisor,
  output frve_pkg::frve_unit_stat_t   stat,
  output logic [frve_pkg::NUM_W-1:0]  quotient
);
  import frve_pkg::*;

  logic [NUM_W-1:0]     num;
  logic [HOP_W-1:0]     rem;
  logic [HOP_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [HOP_W:0]       trial;
  logic                 ge;
  logic [HOP_W-1:0]     rem_next;

  always_comb begin
    trial    = {rem, num[NUM_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? HOP_W'(trial - {1'b0, dvs}) : trial[HOP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // numerator shifts out at the top while quotient bits fill in from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      num <= {dividend, {FRAC_SHIFT{1'b0}}};
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      num <= {num[NUM_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign stat     = '{busy: busy, done: done};
  assign quotient = num;

endmodule

/* rtl/frve_sqrt.sv */
// digit-by-digit square root, two radicand bits and one root bit a cycle
module frve_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [frve_pkg::NUM_W-1:0]  radicand,
  output frve_pkg::frve_unit_stat_t   stat,
  output logic [frve_pkg::VOL_W-1:0]  root_low
);
  import frve_pkg::*;

  logic [RAD_W-1:0]      rad;
  logic [ROOT_W-1:0]     root;
  logic [REM_W-1:0]      rem;
  logic [SQRT_CNT_W-1:0] cnt;
  logic                  busy;
  logic                  done;
  logic [REM_W+1:0]      cur;
  logic [REM_W+1:0]      trial;
  logic                  ge;

  always_comb begin
    cur   = {rem, rad[RAD_W-1 -: 2]};
    trial = (REM_W + 2)'({root, 2'b01});
    ge    = cur >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == SQRT_CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= RAD_W'(radicand);
      root <= '0;
      rem  <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      root <= {root[ROOT_W-2:0], ge};
      rem  <= ge ? REM_W'(cur - trial) : cur[REM_W-1:0];
    end
  end

  // volume field keeps only the low bits of the root
  assign stat     = '{busy: busy, done: done};
  assign root_low = root[VOL_W-1:0];

endmodule

/* rtl/frame_rms_volume_envelope_unit.sv */
// Frame RMS volume envelope: one 16-bit sample per item, one result per full frame of frame_len
// samples (plus a lead frame of |sample|*256 for the first sample of a clip), volume =
// floor(sqrt(sum_of_squares*65536/hop)) with frame_index counting up from 0 within the clip.
// Items are handled one at a time. An item that closes no frame passes a serial square-and-add,
// a check and a closing state before the next accept; the first item of a clip also passes a
// lead state. An item that closes a frame also runs the bit-serial divider and then the
// bit-serial square root before its result is loaded. A finished result sits in the
// output register, so the next item is taken while it waits; a new result that finds the
// previous one still held waits for it, input stalled. clip_end drops any partial frame and
// restarts the frame index. frame_len of 0 acts as 1, above 4096 as 4096; cfg_ready is always
// high and frame_len should be written only while no item is in flight.
module frame_rms_volume_envelope_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [frve_pkg::SAMPLE_W-1:0] sample,
  input  logic                          clip_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [frve_pkg::VOL_W-1:0]    volume,
  output logic [frve_pkg::IDX_W-1:0]    frame_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [frve_pkg::HOP_W-1:0]    frame_len
);
  import frve_pkg::*;

  frve_state_t state, state_next;

  logic [HOP_W-1:0]  hop_reg;
  logic [HOP_W-1:0]  hop_eff;
  logic [SUM_W-1:0]  square_sum;
  logic [HOP_W-1:0]  samples_in_frame;
  logic [HOP_W-1:0]  count_inc;
  logic              clip_started;
  logic [IDX_W-1:0]  frame_count;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  mag_q;
  logic [SQ_W-1:0]   mcand;
  logic [MAG_W-1:0]  mplier;
  logic [MUL_CNT_W-1:0] mul_cnt;
  logic              end_q;
  logic              accept;
  logic              out_free;
  logic              frame_full;
  logic              div_start;
  logic              sqrt_start;
  logic              load_lead;
  logic              load_frame;
  frve_unit_stat_t   div_stat;
  frve_unit_stat_t   sqrt_stat;
  logic [NUM_W-1:0]  quotient;
  logic [VOL_W-1:0]  root_low;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign mag       = sample[SAMPLE_W-1] ? MAG_W'(~sample + 1'b1) : MAG_W'(sample);
  assign count_inc = samples_in_frame + 1'b1;

  always_comb begin
    if (hop_reg == '0) begin
      hop_eff = HOP_W'(1);
    end else if (hop_reg > HOP_W'(MAX_HOP)) begin
      hop_eff = HOP_W'(MAX_HOP);
    end else begin
      hop_eff = hop_reg;
    end
  end

  assign frame_full = count_inc >= hop_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    load_lead  = 1'b0;
    load_frame = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = clip_started ? S_MUL : S_LEAD;
        end
      end
      S_LEAD: begin
        if (out_free) begin
          load_lead  = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_cnt == MUL_CNT_W'(MAG_W - 1)) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (frame_full) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          sqrt_start = 1'b1;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_stat.done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_frame = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_reg <= HOP_W'(HOP_RESET);
    end else if (cfg_valid && cfg_ready) begin
      hop_reg <= frame_len;
    end
  end

  // clip state: frame energy, fill count, lead flag and frame number
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum       <= '0;
      samples_in_frame <= '0;
      clip_started     <= 1'b0;
      frame_count      <= '0;
    end else begin
      if (state == S_MUL && mplier[0]) begin
        square_sum <= square_sum + SUM_W'(mcand);
      end
      if (state == S_CHECK) begin
        if (frame_full) begin
          square_sum       <= '0;
          samples_in_frame <= '0;
        end else begin
          samples_in_frame <= count_inc;
        end
      end
      if (load_lead) begin
        clip_started <= 1'b1;
      end
      if (load_lead || load_frame) begin
        frame_count <= frame_count + 1'b1;
      end
      if (state == S_DONE && end_q) begin
        square_sum       <= '0;
        samples_in_frame <= '0;
        clip_started     <= 1'b0;
        frame_count      <= '0;
      end
    end
  end

  // serial square: shift-and-add over the magnitude bits
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_cnt <= '0;
    end else if (accept) begin
      mul_cnt <= '0;
    end else if (state == S_MUL) begin
      mul_cnt <= mul_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag_q  <= mag;
      mcand  <= SQ_W'(mag);
      mplier <= mag;
      end_q  <= clip_end;
    end else if (state == S_MUL) begin
      mcand  <= {mcand[SQ_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[MAG_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_lead || load_frame) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_lead) begin
      volume      <= VOL_W'({mag_q, {LEAD_SHIFT{1'b0}}});
      frame_index <= frame_count;
    end else if (load_frame) begin
      volume      <= root_low;
      frame_index <= frame_count;
    end
  end

  frve_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (square_sum),
    .divisor  (hop_eff),
    .stat     (div_stat),
    .quotient (quotient)
  );

  frve_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (quotient),
    .stat     (sqrt_stat),
    .root_low (root_low)
  );

  a_idle_units_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!div_stat.busy && !sqrt_stat.busy))
    else $error("divider or root unit busy while waiting for an item");

  a_frame_fill_bound: assert property (@(posedge clk) disable iff (rst)
    samples_in_frame < HOP_W'(MAX_HOP))
    else $error("frame fill count reached the largest hop");

  a_clip_end_clears: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_DONE && $past(end_q)) |-> (!clip_started && frame_count == '0))
    else $error("clip state not cleared after the last item of a clip");

endmodule
